>>> hw/rtl/qws_pkg.sv
package qws_pkg;

  // Character set sizes
  localparam int unsigned DELIM_SLOTS = 4;
  localparam int unsigned QUOTE_SLOTS = 2;
  localparam int unsigned DelimW      = 8 * DELIM_SLOTS;
  localparam int unsigned QuoteW      = 8 * QUOTE_SLOTS;

  // Configuration port
  localparam int unsigned CfgDataW = (DelimW > QuoteW) ? DelimW : QuoteW;
  localparam int unsigned CfgIdxW  = 2;

  // Register reset values
  localparam logic [DelimW-1:0] DelimReset  = DelimW'(64'h0000_0000_000A_0920);
  localparam logic [QuoteW-1:0] QuoteReset  = QuoteW'(32'h0000_2722);
  localparam logic [7:0]        EscapeReset = 8'h5C;

  // Results one item can cause, one slot each
  localparam int unsigned NumSlots = 5;
  localparam int unsigned SelW     = $clog2(NumSlots);

  // Queue between front and back (power of two)
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DELIM  = 2'd0,
    REG_QUOTE  = 2'd1,
    REG_ESCAPE = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_LIST_END = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] chr;
  } slot_t;

  // All results of one item, in order of slot index; en marks the live ones
  typedef struct packed {
    logic  [NumSlots-1:0] en;
    slot_t [NumSlots-1:0] slot;
  } bundle_t;

endpackage

>>> hw/rtl/qws_front.sv
module qws_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_valid_i,
  input  logic [qws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qws_pkg::CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                         accept_i,
  input  logic [7:0]                   in_char_i,
  input  logic                         char_valid_i,
  input  logic                         string_end_i,
  // result bundle toward the queue
  output logic                         bundle_valid_o,
  output qws_pkg::bundle_t             bundle_o
);

  // Slot order of the results of one item
  localparam int unsigned SlotLead   = 0; // escape byte or word end before the char
  localparam int unsigned SlotChar   = 1;
  localparam int unsigned SlotEndEsc = 2; // trailing escape at string end
  localparam int unsigned SlotEndWrd = 3;
  localparam int unsigned SlotEndLst = 4;

  logic [qws_pkg::DelimW-1:0] delim_q;
  logic [qws_pkg::QuoteW-1:0] quote_q;
  logic [7:0]                 esc_q;

  logic [7:0] open_quote_q, open_quote_d;
  logic       esc_pend_q, esc_pend_d;
  logic       word_open_q, word_open_d;
  logic       brk_pend_q, brk_pend_d;

  logic is_esc, is_q, is_d;

  function automatic logic in_delim(logic [qws_pkg::DelimW-1:0] set, logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < qws_pkg::DELIM_SLOTS; i++) begin
      if (set[8*i +: 8] != 8'd0 && set[8*i +: 8] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic in_quote(logic [qws_pkg::QuoteW-1:0] set, logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < qws_pkg::QUOTE_SLOTS; i++) begin
      if (set[8*i +: 8] != 8'd0 && set[8*i +: 8] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  // Classify the byte
  assign is_esc = (esc_q != 8'd0) && (in_char_i == esc_q);
  assign is_q   = in_quote(quote_q, in_char_i);
  assign is_d   = in_delim(delim_q, in_char_i);

  // Next state and result slots
  always_comb begin
    open_quote_d = open_quote_q;
    esc_pend_d   = esc_pend_q;
    word_open_d  = word_open_q;
    brk_pend_d   = brk_pend_q;

    bundle_o.en = '0;
    bundle_o.slot[SlotLead]   = '{kind: qws_pkg::KIND_CHAR,     chr: esc_q};
    bundle_o.slot[SlotChar]   = '{kind: qws_pkg::KIND_CHAR,     chr: in_char_i};
    bundle_o.slot[SlotEndEsc] = '{kind: qws_pkg::KIND_CHAR,     chr: esc_q};
    bundle_o.slot[SlotEndWrd] = '{kind: qws_pkg::KIND_WORD_END, chr: 8'd0};
    bundle_o.slot[SlotEndLst] = '{kind: qws_pkg::KIND_LIST_END, chr: 8'd0};

    if (char_valid_i) begin
      if (open_quote_q != 8'd0) begin
        // inside a quoted span
        if (esc_pend_q) begin
          bundle_o.en[SlotLead] = (in_char_i != open_quote_q) && !is_esc;
          bundle_o.en[SlotChar] = 1'b1;
          esc_pend_d = 1'b0;
        end else if (in_char_i == open_quote_q) begin
          open_quote_d = 8'd0;
        end else if (is_esc) begin
          esc_pend_d = 1'b1;
        end else begin
          bundle_o.en[SlotChar] = 1'b1;
        end
      end else if (esc_pend_q) begin
        // escape keeps itself only before a plain byte
        bundle_o.en[SlotLead] = !is_esc && !is_q && !is_d;
        bundle_o.en[SlotChar] = 1'b1;
        esc_pend_d = 1'b0;
      end else if (is_d && !is_q) begin
        if (word_open_q) brk_pend_d = 1'b1;
      end else begin
        // byte starts or continues a word
        if (brk_pend_q) begin
          bundle_o.en[SlotLead]   = 1'b1;
          bundle_o.slot[SlotLead] = '{kind: qws_pkg::KIND_WORD_END, chr: 8'd0};
          brk_pend_d = 1'b0;
        end
        word_open_d = 1'b1;
        if (is_q) begin
          open_quote_d = in_char_i;
        end else if (is_esc) begin
          esc_pend_d = 1'b1;
        end else begin
          bundle_o.en[SlotChar] = 1'b1;
        end
      end
    end

    if (string_end_i) begin
      bundle_o.en[SlotEndEsc] = esc_pend_d;
      bundle_o.en[SlotEndWrd] = word_open_d;
      bundle_o.en[SlotEndLst] = 1'b1;
      open_quote_d = 8'd0;
      esc_pend_d   = 1'b0;
      word_open_d  = 1'b0;
      brk_pend_d   = 1'b0;
    end
  end

  assign bundle_valid_o = accept_i && (bundle_o.en != '0);

  // Configuration registers and splitter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q      <= qws_pkg::DelimReset;
      quote_q      <= qws_pkg::QuoteReset;
      esc_q        <= qws_pkg::EscapeReset;
      open_quote_q <= 8'd0;
      esc_pend_q   <= 1'b0;
      word_open_q  <= 1'b0;
      brk_pend_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (qws_pkg::cfg_reg_e'(cfg_index_i))
          qws_pkg::REG_DELIM:  delim_q <= cfg_data_i[qws_pkg::DelimW-1:0];
          qws_pkg::REG_QUOTE:  quote_q <= cfg_data_i[qws_pkg::QuoteW-1:0];
          qws_pkg::REG_ESCAPE: esc_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        open_quote_q <= open_quote_d;
        esc_pend_q   <= esc_pend_d;
        word_open_q  <= word_open_d;
        brk_pend_q   <= brk_pend_d;
      end
    end
  end

endmodule

>>> hw/rtl/qws_queue.sv
module qws_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  qws_pkg::bundle_t wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             empty_o,
  output qws_pkg::bundle_t rdata_o
);

  qws_pkg::bundle_t mem_q [qws_pkg::QueueDepth];

  logic [qws_pkg::QueuePtrW-1:0] wptr_q, rptr_q;
  logic [qws_pkg::QueuePtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (qws_pkg::QueuePtrW+1)'(qws_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wptr_q] <= wdata_i;
  end

  // Pointers wrap at the power-of-two depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i && !full_o) wptr_q <= wptr_q + 1'b1;
      if (rd_i && !empty_o) rptr_q <= rptr_q + 1'b1;
      if ((wr_i && !full_o) && !(rd_i && !empty_o)) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!(wr_i && !full_o) && (rd_i && !empty_o)) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/qws_back.sv
module qws_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  // from the queue
  input  logic             q_empty_i,
  input  qws_pkg::bundle_t q_data_i,
  output logic             q_pop_o,
  // result ports
  output logic             empty_o,
  input  logic             pop_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       out_char_o,
  output logic             run_last_o
);

  logic [qws_pkg::NumSlots-1:0] mask_q, mask_d, rest;
  qws_pkg::slot_t [qws_pkg::NumSlots-1:0] slot_q;
  logic [qws_pkg::SelW-1:0] sel;
  logic take, load;

  // Lowest live slot is the oldest result
  always_comb begin
    sel = '0;
    for (int i = qws_pkg::NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = qws_pkg::SelW'(i);
    end
  end

  assign rest    = mask_q & (mask_q - 1'b1);
  assign empty_o = (mask_q == '0);
  assign take    = pop_i && !empty_o;
  assign load    = empty_o || (take && (rest == '0));
  assign q_pop_o = load && !q_empty_i;

  assign result_kind_o = slot_q[sel].kind;
  assign out_char_o    = slot_q[sel].chr;
  assign run_last_o    = (rest == '0);

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = q_empty_i ? '0 : q_data_i.en;
    end else if (take) begin
      mask_d = rest;
    end
  end

  // Bundle being sent out
  always_ff @(posedge clk_i) begin
    if (q_pop_o) slot_q <= q_data_i.slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

endmodule

>>> hw/rtl/quoted_word_splitter.sv
// Path: an accepted item is written into the queue as one bundle, then loaded into the
// result serializer registers, from which its first result appears on the result ports.
// Throughput: one item per cycle while items cause at most one result each and pop stays
// high; an item with several results holds the result serializer until all are popped,
// and the 4-entry queue between classifier and serializer absorbs bursts until full rises.
// Reset: splitter state and queue clear, registers return to space/tab/newline,
// double/single quote and backslash.
module quoted_word_splitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qws_pkg::CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_char_i,
  input  logic                         char_valid_i,
  input  logic                         string_end_i,
  // results
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   result_kind_o,
  output logic [7:0]                   out_char_o,
  output logic                         run_last_o
);

  logic             accept;
  logic             bundle_valid;
  qws_pkg::bundle_t bundle;
  logic             q_full, q_empty, q_pop;
  qws_pkg::bundle_t q_data;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  qws_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .accept_i       (accept),
    .in_char_i,
    .char_valid_i,
    .string_end_i,
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  qws_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i    (bundle_valid),
    .wdata_i (bundle),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  qws_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i     (q_empty),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .result_kind_o,
    .out_char_o,
    .run_last_o
  );

endmodule

>>> hw/rtl/qws_checker.sv
module qws_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] result_kind_o,
  input logic [7:0] out_char_o,
  input logic       run_last_o
);

  // End of list always closes the run of its item
  a_list_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == qws_pkg::KIND_LIST_END) |-> run_last_o)
    else $error("list end without run_last");

  // Marks carry no character
  a_mark_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o != qws_pkg::KIND_CHAR) |-> (out_char_o == 8'd0))
    else $error("mark result with nonzero character");

  // A waiting result always carries a defined kind
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_kind_o == qws_pkg::KIND_CHAR
                || result_kind_o == qws_pkg::KIND_WORD_END
                || result_kind_o == qws_pkg::KIND_LIST_END))
    else $error("result with undefined kind");

  // A waiting result holds until transferred
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_kind_o) && $stable(out_char_o)
                          && $stable(run_last_o)))
    else $error("waiting result changed");

endmodule

bind quoted_word_splitter qws_checker u_qws_checker (.*);

>>> tb/tb_quoted_word_splitter.sv
`timescale 1ns / 1ps

module tb_quoted_word_splitter;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 100;
  localparam int unsigned PhaseItems = 45;

  // One expected or observed result
  typedef struct packed {
    qws_pkg::kind_e kind;
    logic [7:0]     chr;
    logic           last;
  } result_t;

  localparam result_t NoResult = '{qws_pkg::KIND_CHAR, 8'h00, 1'b0};

  // Directed row: stimulus plus an optional hand-written expectation
  typedef struct packed {
    logic [7:0] chr;
    logic       vld;
    logic       fin;
    logic       typed;
    logic       n_exp;
    result_t    exp0;
  } dir_row_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_valid_i  = 1'b0;
  logic                         cfg_ready_o;
  logic [qws_pkg::CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [qws_pkg::CfgDataW-1:0] cfg_data_i   = '0;
  logic                         push         = 1'b0;
  logic                         full;
  logic [7:0]                   in_char_i    = 8'h00;
  logic                         char_valid_i = 1'b0;
  logic                         string_end_i = 1'b0;
  logic                         empty;
  logic                         pop          = 1'b0;
  logic [1:0]                   result_kind_o;
  logic [7:0]                   out_char_o;
  logic                         run_last_o;

  quoted_word_splitter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .in_char_i    (in_char_i),
    .char_valid_i (char_valid_i),
    .string_end_i (string_end_i),
    .empty        (empty),
    .pop          (pop),
    .result_kind_o(result_kind_o),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Splitter mirror: registers and word state
  logic [qws_pkg::DelimW-1:0] cur_delim   = qws_pkg::DelimReset;
  logic [qws_pkg::QuoteW-1:0] cur_quote   = qws_pkg::QuoteReset;
  logic [7:0]                 cur_escape  = qws_pkg::EscapeReset;
  logic [7:0]                 open_quote  = 8'h00;
  logic                       esc_pending = 1'b0;
  logic                       word_open   = 1'b0;
  logic                       brk_pending = 1'b0;

  result_t step_res[$];
  result_t pending_results[$];

  int unsigned send_idle_pct  = 33;
  int unsigned recv_idle_pct  = 64;
  int unsigned hold_requests  = 0;
  int unsigned holds_done     = 0;
  int unsigned error_count    = 0;
  int unsigned item_count     = 0;
  int unsigned string_count   = 0;
  int unsigned result_count   = 0;
  int unsigned settings_count = 1;
  int unsigned stall_cycles   = 0;

  // Directed rows, default registers; hand-written results on the first six
  dir_row_t dir_rows [0:26] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, '{qws_pkg::KIND_LIST_END, 8'h00, 1'b1}}, // empty string
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NoResult},                        // bare item
    '{8'h20, 1'b1, 1'b0, 1'b1, 1'b0, NoResult},                        // leading delimiter
    '{8'h61, 1'b1, 1'b0, 1'b1, 1'b1, '{qws_pkg::KIND_CHAR, 8'h61, 1'b1}},
    '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, '{qws_pkg::KIND_CHAR, 8'hFF, 1'b1}},
    '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, '{qws_pkg::KIND_CHAR, 8'h00, 1'b1}}, // zero byte
    '{8'h09, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // break after word
    '{8'h62, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},
    '{8'h22, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // open double quote
    '{8'h20, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // quoted delimiter
    '{8'h27, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // other quote as text
    '{8'h5C, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},
    '{8'h78, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // escape kept
    '{8'h5C, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},
    '{8'h22, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // escaped close quote
    '{8'h22, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // close quote
    '{8'h5C, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},
    '{8'h20, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // escaped delimiter
    '{8'h0A, 1'b1, 1'b1, 1'b0, 1'b0, NoResult},                        // trailing delimiter
    '{8'h22, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // empty word
    '{8'h22, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},
    '{8'h5C, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},
    '{8'h7A, 1'b1, 1'b1, 1'b0, 1'b0, NoResult},                        // four results
    '{8'h5C, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // trailing escape
    '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, NoResult},
    '{8'h27, 1'b1, 1'b0, 1'b0, 1'b0, NoResult},                        // unclosed quote
    '{8'h71, 1'b1, 1'b1, 1'b0, 1'b0, NoResult}
  };

  function automatic bit in_slots(input logic [31:0] set_bits, input int unsigned slots,
                                  input logic [7:0] c);
    for (int unsigned i = 0; i < slots; i++) begin
      if (set_bits[8*i +: 8] != 8'h00 && set_bits[8*i +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_result(input qws_pkg::kind_e kind, input logic [7:0] c);
    step_res.push_back('{kind, (kind == qws_pkg::KIND_CHAR) ? c : 8'h00, 1'b0});
  endfunction

  // Results of one item, updates the mirrored word state
  task automatic split_step(input logic [7:0] c, input logic v, input logic e);
    logic is_esc, is_q, is_d;
    step_res.delete();
    is_esc = (cur_escape != 8'h00) && (c == cur_escape);
    is_q   = in_slots(32'(cur_quote), qws_pkg::QUOTE_SLOTS, c);
    is_d   = in_slots(32'(cur_delim), qws_pkg::DELIM_SLOTS, c);
    if (v) begin
      if (open_quote != 8'h00) begin
        if (esc_pending) begin
          if (c != open_quote && !is_esc) add_result(qws_pkg::KIND_CHAR, cur_escape);
          add_result(qws_pkg::KIND_CHAR, c);
          esc_pending = 1'b0;
        end else if (c == open_quote) begin
          open_quote = 8'h00;
        end else if (is_esc) begin
          esc_pending = 1'b1;
        end else begin
          add_result(qws_pkg::KIND_CHAR, c);
        end
      end else if (esc_pending) begin
        // escape stays visible unless the next byte was special here
        if (!is_esc && !is_q && !is_d) add_result(qws_pkg::KIND_CHAR, cur_escape);
        add_result(qws_pkg::KIND_CHAR, c);
        esc_pending = 1'b0;
      end else if (is_d && !is_q) begin
        if (word_open) brk_pending = 1'b1;
      end else begin
        if (brk_pending) begin
          add_result(qws_pkg::KIND_WORD_END, 8'h00);
          brk_pending = 1'b0;
        end
        word_open = 1'b1;
        if (is_q) open_quote = c;
        else if (is_esc) esc_pending = 1'b1;
        else add_result(qws_pkg::KIND_CHAR, c);
      end
    end
    if (e) begin
      if (esc_pending) add_result(qws_pkg::KIND_CHAR, cur_escape);
      if (word_open) add_result(qws_pkg::KIND_WORD_END, 8'h00);
      add_result(qws_pkg::KIND_LIST_END, 8'h00);
      open_quote  = 8'h00;
      esc_pending = 1'b0;
      word_open   = 1'b0;
      brk_pending = 1'b0;
    end
    if (step_res.size() != 0) step_res[step_res.size()-1].last = 1'b1;
  endtask

  // Offer one item, wait for the transfer, then record what it should cause
  task automatic feed(input logic [7:0] c, input logic v, input logic e, input bit use_pred);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    in_char_i    <= c;
    char_valid_i <= v;
    string_end_i <= e;
    do @(posedge clk_i); while (!(push && !full));
    split_step(c, v, e);
    if (use_pred) foreach (step_res[k]) pending_results.push_back(step_res[k]);
    if (v || e) item_count++;
    if (e) string_count++;
  endtask

  // Block is idle once all results are out and items without results have settled
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input qws_pkg::cfg_reg_e idx,
                           input logic [qws_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    case (idx)
      qws_pkg::REG_DELIM:  cur_delim  = data[qws_pkg::DelimW-1:0];
      qws_pkg::REG_QUOTE:  cur_quote  = data[qws_pkg::QuoteW-1:0];
      qws_pkg::REG_ESCAPE: cur_escape = data[7:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise; the block must ignore them
  task automatic configure(input logic [31:0] delim, input logic [15:0] quote,
                           input logic [7:0] esc);
    wait_idle();
    write_reg(qws_pkg::REG_DELIM, delim);
    write_reg(qws_pkg::REG_QUOTE, {16'($urandom), quote});
    write_reg(qws_pkg::REG_ESCAPE, {24'($urandom), esc});
    cfg_valid_i <= 1'b0;
    settings_count++;
  endtask

  // Bytes biased toward the current special sets
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return cur_delim[8*$urandom_range(qws_pkg::DELIM_SLOTS-1) +: 8];
    if (r < 35) return cur_quote[8*$urandom_range(qws_pkg::QUOTE_SLOTS-1) +: 8];
    if (r < 45) return cur_escape;
    if (r < 85) return 8'h61 + 8'($urandom_range(25));
    return 8'($urandom);
  endfunction

  // Random strings with sprinkled bare items
  task automatic run_phase(input int unsigned quota);
    int unsigned start_count, len;
    bit end_on_char;
    start_count = item_count;
    while (item_count - start_count < quota) begin
      len = $urandom_range(0, 10);
      end_on_char = (len != 0) && ($urandom_range(3) != 0);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) feed(8'($urandom), 1'b0, 1'b0, 1'b1);
        feed(pick_char(), 1'b1, end_on_char && (i == len - 1), 1'b1);
      end
      if (!end_on_char) feed(8'($urandom), 1'b0, 1'b1, 1'b1);
    end
  endtask

  // Result side: random pop, plus a long hold on request
  initial begin : result_sink
    result_t exp_r;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d char 0x%02h last %0b",
                 result_kind_o, out_char_o, run_last_o);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (2'(exp_r.kind) !== result_kind_o) begin
            $error("result_kind: expected %0d, got %0d", exp_r.kind, result_kind_o);
            error_count++;
          end
          if (exp_r.chr !== out_char_o) begin
            $error("out_char: expected 0x%02h, got 0x%02h", exp_r.chr, out_char_o);
            error_count++;
          end
          if (exp_r.last !== run_last_o) begin
            $error("run_last: expected %0b, got %0b", exp_r.last, run_last_o);
            error_count++;
          end
        end
      end
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 stall_cycles, pending_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows under reset registers
    foreach (dir_rows[i]) begin
      feed(dir_rows[i].chr, dir_rows[i].vld, dir_rows[i].fin, !dir_rows[i].typed);
      if (dir_rows[i].typed && dir_rows[i].n_exp) pending_results.push_back(dir_rows[i].exp0);
    end
    run_phase(PhaseItems);

    // All three sets collapse onto 0xFF: quote test wins
    configure(32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    run_phase(PhaseItems);

    // Sender slow, receiver fast
    send_idle_pct = 64;
    recv_idle_pct = 33;
    configure(32'h0000_0000, 16'h0000, 8'h01);
    run_phase(PhaseItems);

    // Overlapping sets: quote byte also a delimiter, escape also a quote
    configure(32'h5C22_2C20, 16'h2C27, 8'h27);
    run_phase(PhaseItems);

    // No idling; escape disabled; long result hold fills the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(32'h0000_0A3B, 16'h0060, 8'h00);
    hold_requests++;
    run_phase(PhaseItems);

    configure($urandom, 16'($urandom), 8'($urandom_range(1, 255)));
    run_phase(PhaseItems);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results from %0d items in %0d strings over %0d register settings.",
             result_count, item_count, string_count, settings_count);
    $display("Covered quoting, escapes, empty words, overlapping sets and a full-block stall.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
